>>> sv/csn_pkg.sv
// csn_pkg: shared codes and fixed constants for the colour sensor normaliser.
// No dependencies; queue and divider aside, every file uses its scoped names.
`timescale 1ns / 1ps

package csn_pkg;

  // Width and reset value of the samples-per-reading register
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 5;

  // Red, green and blue; channel code three is not a colour
  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = 2;
  localparam int MASK_W       = 2 * NUM_CHANNELS;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_WHITE   = 2'd0,
    OP_BLACK   = 2'd1,
    OP_MEASURE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_MEASURED   = 2'd0,
    ST_CAPTURED   = 2'd1,
    ST_ZERO_RANGE = 2'd2
  } status_t;

endpackage

>>> sv/csn_if.sv
// csn_if: valid/ready channel interfaces for sample beats and reading beats.
// Depends on csn_pkg for the channel width and the status type.
`timescale 1ns / 1ps

interface csn_in_if #(
  parameter int ADC_BITS = 10
);
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [csn_pkg::CH_W-1:0]  channel;
  logic [ADC_BITS-1:0]       sample;

  modport source (output valid, output operation, output channel, output sample,
                  input ready);
  modport sink   (input valid, input operation, input channel, input sample,
                  output ready);
endinterface

interface csn_out_if #(
  parameter int ADC_BITS = 10,
  parameter int VALUE_W  = 19
);
  logic                        valid;
  logic                        ready;
  logic [csn_pkg::CH_W-1:0]    out_channel;
  logic [ADC_BITS-1:0]         average;
  logic signed [VALUE_W-1:0]   value;
  csn_pkg::status_t            status;
  logic                        calibrated;

  modport source (output valid, output out_channel, output average, output value,
                  output status, output calibrated, input ready);
  modport sink   (input valid, input out_channel, input average, input value,
                  input status, input calibrated, output ready);
endinterface

>>> sv/csn_front.sv
// csn_front: takes sample beats, drops bad codes, accumulates per reading and
// pushes one job per finished reading. Depends on csn_pkg and csn_if.
`timescale 1ns / 1ps

module csn_front #(
  parameter int ADC_BITS    = 10,
  parameter int MAX_SAMPLES = 16,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int SUM_W       = ADC_BITS + $clog2(MAX_SAMPLES)
) (
  input  logic                        clk,
  input  logic                        rst,
  csn_in_if.sink                      samples,
  input  logic [csn_pkg::CFG_W-1:0]   count_cfg,
  input  logic                        queue_full,
  output logic                        push,
  output logic [1:0]                  job_op,
  output logic [csn_pkg::CH_W-1:0]    job_ch,
  output logic [SUM_W-1:0]            job_sum,
  output logic [CNT_W-1:0]            job_cnt
);

  logic [SUM_W-1:0]           sum;
  logic [CNT_W-1:0]           taken;
  logic [1:0]                 run_op;
  logic [csn_pkg::CH_W-1:0]   run_ch;

  logic                       accept;
  logic                       good_item;
  logic                       restart;
  logic [CNT_W-1:0]           n_eff;
  logic [SUM_W-1:0]           sum_next;
  logic [CNT_W-1:0]           taken_next;
  logic                       reading_done;

  assign samples.ready = !queue_full;
  assign accept        = samples.valid && samples.ready;

  // Only white, black and measure on a real colour count
  assign good_item = (samples.operation == csn_pkg::OP_WHITE ||
                      samples.operation == csn_pkg::OP_BLACK ||
                      samples.operation == csn_pkg::OP_MEASURE) &&
                     (int'(samples.channel) < csn_pkg::NUM_CHANNELS);

  // Clamp the programmed count to 1..MAX_SAMPLES
  always_comb begin
    if (count_cfg == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(count_cfg) > MAX_SAMPLES) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = CNT_W'(count_cfg);
    end
  end

  // A new operation or channel drops what was gathered so far
  assign restart      = (samples.operation != run_op) || (samples.channel != run_ch);
  assign sum_next     = (restart ? '0 : sum) + SUM_W'(samples.sample);
  assign taken_next   = (restart ? '0 : taken) + CNT_W'(1);
  assign reading_done = (taken_next >= n_eff);

  assign push    = accept && good_item && reading_done;
  assign job_op  = samples.operation;
  assign job_ch  = samples.channel;
  assign job_sum = sum_next;
  assign job_cnt = n_eff;

  // Accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      taken  <= '0;
      run_op <= '0;
      run_ch <= '0;
    end else if (accept && good_item) begin
      run_op <= samples.operation;
      run_ch <= samples.channel;
      if (reading_done) begin
        sum   <= '0;
        taken <= '0;
      end else begin
        sum   <= sum_next;
        taken <= taken_next;
      end
    end
  end

endmodule

>>> sv/csn_queue.sv
// csn_queue: small register FIFO holding reading jobs between front and back.
// No package dependencies.
`timescale 1ns / 1ps

module csn_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/csn_div.sv
// csn_div: unsigned restoring divider, one quotient bit per cycle.
// No package dependencies. Shared by the mean and the normalisation.
`timescale 1ns / 1ps

module csn_div #(
  parameter int DVD_W = 18,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;
  logic              busy;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  trial;
  logic              fits;

  // One restoring step
  assign shifted = {rem, quo[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};
  assign fits    = !trial[DVS_W+1];

  assign quotient = quo;

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/csn_back.sv
// csn_back: takes jobs from the queue, forms the mean, stores references or
// normalises a measurement, and drives the reading channel. Depends on
// csn_pkg, csn_if and an external csn_div.
`timescale 1ns / 1ps

module csn_back #(
  parameter int ADC_BITS    = 10,
  parameter int MAX_SAMPLES = 16,
  parameter int FULL_SCALE  = 255,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int SUM_W       = ADC_BITS + $clog2(MAX_SAMPLES),
  parameter int NUM_W       = ADC_BITS + $clog2(FULL_SCALE + 1),
  parameter int VALUE_W     = NUM_W + 1,
  parameter int DVD_W       = (SUM_W > NUM_W) ? SUM_W : NUM_W,
  parameter int DVS_W       = (ADC_BITS > CNT_W) ? ADC_BITS : CNT_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_pop,
  input  logic [1:0]                 job_op,
  input  logic [csn_pkg::CH_W-1:0]   job_ch,
  input  logic [SUM_W-1:0]           job_sum,
  input  logic [CNT_W-1:0]           job_cnt,
  output logic                       div_start,
  output logic [DVD_W-1:0]           div_dividend,
  output logic [DVS_W-1:0]           div_divisor,
  input  logic                       div_done,
  input  logic [DVD_W-1:0]           div_quotient,
  csn_out_if.source                  readings
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_AVG   = 5'b00010,
    S_APPLY = 5'b00100,
    S_NORM  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                          state;
  logic [1:0]                      cur_op;
  logic [csn_pkg::CH_W-1:0]        cur_ch;
  logic [ADC_BITS-1:0]             avg;
  logic                            neg_result;
  logic [ADC_BITS-1:0]             white_ref [csn_pkg::NUM_CHANNELS];
  logic [ADC_BITS-1:0]             black_ref [csn_pkg::NUM_CHANNELS];
  logic [csn_pkg::MASK_W-1:0]      mask;
  csn_pkg::status_t                res_status;
  logic signed [VALUE_W-1:0]       res_value;

  logic                            out_valid;
  logic [csn_pkg::CH_W-1:0]        out_ch;
  logic [ADC_BITS-1:0]             out_avg;
  logic signed [VALUE_W-1:0]       out_value;
  csn_pkg::status_t                out_status;
  logic                            out_cal;

  logic [ADC_BITS-1:0]             ref_w;
  logic [ADC_BITS-1:0]             ref_b;
  logic signed [ADC_BITS:0]        range_s;
  logic signed [ADC_BITS:0]        diff_s;
  logic [ADC_BITS:0]               range_abs;
  logic [ADC_BITS:0]               diff_abs;
  logic                            range_zero;
  logic [NUM_W-1:0]                num_mag;
  logic [VALUE_W-1:0]              quo_ext;
  logic                            measure_go;
  logic                            emit_go;

  // Reference lookup and signed differences for the current channel
  assign ref_w      = white_ref[cur_ch];
  assign ref_b      = black_ref[cur_ch];
  assign range_s    = $signed({1'b0, ref_w}) - $signed({1'b0, ref_b});
  assign diff_s     = $signed({1'b0, avg}) - $signed({1'b0, ref_b});
  assign range_abs  = range_s[ADC_BITS] ? (ADC_BITS + 1)'(0) - range_s : range_s;
  assign diff_abs   = diff_s[ADC_BITS] ? (ADC_BITS + 1)'(0) - diff_s : diff_s;
  assign range_zero = (range_s == '0);
  assign num_mag    = NUM_W'(diff_abs[ADC_BITS-1:0]) * NUM_W'(FULL_SCALE);
  assign quo_ext    = {1'b0, div_quotient[NUM_W-1:0]};

  assign measure_go = (state == S_APPLY) && (cur_op == csn_pkg::OP_MEASURE) && !range_zero;
  assign emit_go    = (state == S_EMIT) && (!out_valid || readings.ready);

  // Divider requests: the mean from the queue head, then the normalisation
  assign job_pop      = (state == S_IDLE) && job_valid;
  assign div_start    = job_pop || measure_go;
  assign div_dividend = job_pop ? DVD_W'(job_sum) : DVD_W'(num_mag);
  assign div_divisor  = job_pop ? DVS_W'(job_cnt) : DVS_W'(range_abs[ADC_BITS-1:0]);

  // Sequencer, references and capture mask
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mask  <= '0;
      for (int i = 0; i < csn_pkg::NUM_CHANNELS; i++) begin
        white_ref[i] <= '0;
        black_ref[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (cur_op == csn_pkg::OP_WHITE) begin
            white_ref[cur_ch] <= avg;
            mask[cur_ch]      <= 1'b1;
            state             <= S_EMIT;
          end else if (cur_op == csn_pkg::OP_BLACK) begin
            black_ref[cur_ch] <= avg;
            mask[3'(cur_ch) + 3'(csn_pkg::NUM_CHANNELS)] <= 1'b1;
            state             <= S_EMIT;
          end else if (range_zero) begin
            state <= S_EMIT;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Job and result holding registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_op <= job_op;
      cur_ch <= job_ch;
    end
    if (state == S_AVG && div_done) begin
      avg <= div_quotient[ADC_BITS-1:0];
    end
    if (state == S_APPLY) begin
      neg_result <= diff_s[ADC_BITS] ^ range_s[ADC_BITS];
      res_value  <= '0;
      if (cur_op != csn_pkg::OP_MEASURE) begin
        res_status <= csn_pkg::ST_CAPTURED;
      end else if (range_zero) begin
        res_status <= csn_pkg::ST_ZERO_RANGE;
      end else begin
        res_status <= csn_pkg::ST_MEASURED;
      end
    end
    if (state == S_NORM && div_done) begin
      res_value <= neg_result ? $signed(VALUE_W'(0) - quo_ext) : $signed(quo_ext);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (readings.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_ch     <= cur_ch;
      out_avg    <= avg;
      out_value  <= res_value;
      out_status <= res_status;
      out_cal    <= &mask;
    end
  end

  assign readings.valid       = out_valid;
  assign readings.out_channel = out_ch;
  assign readings.average     = out_avg;
  assign readings.value       = out_value;
  assign readings.status      = out_status;
  assign readings.calibrated  = out_cal;

endmodule

>>> sv/colour_sensor_two_point_normalizer.sv
// Two-point colour sensor normaliser: one sample beat is taken per cycle while the
// job queue has room; a reading finishes on its last sample. A reference capture
// passes once through the one-bit-per-cycle divider, for the mean; a measurement
// passes twice, for the mean and then the ratio, unless its reference range is zero.
// Synchronous active-high reset clears references, capture mask, accumulator,
// queue and handshakes, and loads 5 into the samples-per-reading register.
`timescale 1ns / 1ps

module colour_sensor_two_point_normalizer #(
  parameter int ADC_BITS    = 10,
  parameter int MAX_SAMPLES = 16,
  parameter int FULL_SCALE  = 255
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [csn_pkg::CFG_W-1:0]  cfg_wdata,
  csn_in_if.sink                     samples,
  csn_out_if.source                  readings
);

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W   = ADC_BITS + $clog2(MAX_SAMPLES);
  localparam int NUM_W   = ADC_BITS + $clog2(FULL_SCALE + 1);
  localparam int DVD_W   = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DVS_W   = (ADC_BITS > CNT_W) ? ADC_BITS : CNT_W;
  localparam int JOB_W   = 2 + csn_pkg::CH_W + SUM_W + CNT_W;

  logic [csn_pkg::CFG_W-1:0]  samples_per_reading;

  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  logic [JOB_W-1:0]           q_wdata;
  logic [JOB_W-1:0]           q_rdata;

  logic [1:0]                 f_op;
  logic [csn_pkg::CH_W-1:0]   f_ch;
  logic [SUM_W-1:0]           f_sum;
  logic [CNT_W-1:0]           f_cnt;

  logic [1:0]                 b_op;
  logic [csn_pkg::CH_W-1:0]   b_ch;
  logic [SUM_W-1:0]           b_sum;
  logic [CNT_W-1:0]           b_cnt;

  logic                       div_start;
  logic [DVD_W-1:0]           div_dividend;
  logic [DVS_W-1:0]           div_divisor;
  logic                       div_done;
  logic [DVD_W-1:0]           div_quotient;

  // Samples-per-reading register
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_reading <= csn_pkg::CFG_W'(csn_pkg::CFG_RESET);
    end else if (cfg_we) begin
      samples_per_reading <= cfg_wdata;
    end
  end

  csn_front #(
    .ADC_BITS    (ADC_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .count_cfg  (samples_per_reading),
    .queue_full (q_full),
    .push       (q_push),
    .job_op     (f_op),
    .job_ch     (f_ch),
    .job_sum    (f_sum),
    .job_cnt    (f_cnt)
  );

  // Job packing across the queue
  assign q_wdata = {f_op, f_ch, f_sum, f_cnt};
  assign {b_op, b_ch, b_sum, b_cnt} = q_rdata;

  csn_queue #(
    .WIDTH (JOB_W),
    .DEPTH (csn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  csn_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  csn_back #(
    .ADC_BITS    (ADC_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .FULL_SCALE  (FULL_SCALE),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .NUM_W       (NUM_W),
    .VALUE_W     (NUM_W + 1),
    .DVD_W       (DVD_W),
    .DVS_W       (DVS_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (!q_empty),
    .job_pop      (q_pop),
    .job_op       (b_op),
    .job_ch       (b_ch),
    .job_sum      (b_sum),
    .job_cnt      (b_cnt),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .readings     (readings)
  );

endmodule

>>> sv/csn_checker.sv
// csn_checker: port-level checks on the reading channel of the normaliser,
// bound to the top level. Depends on csn_pkg.
`timescale 1ns / 1ps

module csn_checker #(
  parameter int ADC_BITS   = 10,
  parameter int FULL_SCALE = 255,
  parameter int VALUE_W    = ADC_BITS + $clog2(FULL_SCALE + 1) + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [csn_pkg::CH_W-1:0]   out_channel,
  input  logic [ADC_BITS-1:0]        average,
  input  logic signed [VALUE_W-1:0]  value,
  input  csn_pkg::status_t           status,
  input  logic                       calibrated
);

  // Remembers that a calibrated reading has been delivered since reset
  logic seen_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_cal <= 1'b0;
    end else if (out_valid && out_ready && calibrated) begin
      seen_cal <= 1'b1;
    end
  end

  // A stalled beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(average)
      && $stable(value) && $stable(status) && $stable(calibrated))
    else $error("reading beat changed while stalled");

  // Only a measured reading carries a nonzero value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != csn_pkg::ST_MEASURED |-> value == '0)
    else $error("nonzero value on capture or zero-range reading");

  // Nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("reading offered straight after reset");

  // References are never forgotten, so calibration stays set
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_cal |-> calibrated)
    else $error("calibrated flag dropped after being reported");

endmodule

bind colour_sensor_two_point_normalizer csn_checker #(
  .ADC_BITS   (ADC_BITS),
  .FULL_SCALE (FULL_SCALE)
) u_csn_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (readings.valid),
  .out_ready   (readings.ready),
  .out_channel (readings.out_channel),
  .average     (readings.average),
  .value       (readings.value),
  .status      (readings.status),
  .calibrated  (readings.calibrated)
);
